// ===== sv/normal_cdf_erf_approx_macros.svh =====
// assertion macros for the normal cdf / erf block checker
`ifndef NORMAL_CDF_ERF_APPROX_MACROS_SVH
`define NORMAL_CDF_ERF_APPROX_MACROS_SVH

// property checked only outside reset
`define NCDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define NCDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ncdf_pkg.sv =====
// shared constants, fixed-point coefficients and transaction types
`default_nettype none
package ncdf_pkg;

    localparam int ARG_FRAC = 12;
    localparam int RES_FRAC = 16;
    localparam int ARG_W    = 16;
    localparam int VAL_W    = 18;

    // q30 constants, rounded to nearest
    localparam logic [63:0] Q_INV_SQRT2 =
        ((64'd7071067812 << 30) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] Q_LOG2E =
        ((64'd14426950409 << 30) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] Q_LN2 =
        ((64'd6931471806 << 30) + 64'd5000000000) / 64'd10000000000;
    localparam logic [63:0] Q_P  = ((64'd327591100 << 30) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] Q_A1 = ((64'd254829592 << 30) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] Q_A2 = ((64'd284496736 << 30) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] Q_A3 = ((64'd1421413741 << 30) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] Q_A4 = ((64'd1453152027 << 30) + 64'd500000000) / 64'd1000000000;
    localparam logic [63:0] Q_A5 = ((64'd1061405429 << 30) + 64'd500000000) / 64'd1000000000;

    localparam logic [29:0] INV_SQRT2 = Q_INV_SQRT2[29:0];
    localparam logic [30:0] LOG2E     = Q_LOG2E[30:0];
    localparam logic [29:0] LN2       = Q_LN2[29:0];
    localparam logic [28:0] P_COEF    = Q_P[28:0];

    localparam logic [30:0] ONE_Q30 = 31'd1 << 30;
    localparam logic [30:0] X_LIMIT = 31'd1610612736;

    localparam logic signed [33:0] COEF_A5 = 34'(Q_A5);
    localparam logic signed [33:0] COEF_ADD [6] = '{
        -34'(Q_A4), 34'(Q_A3), -34'(Q_A2), 34'(Q_A1), 34'd0, 34'd0
    };

    typedef struct packed {
        logic neg;
        logic mode;
    } t_flags;

    typedef struct packed {
        logic [31:0] d;
        logic [35:0] v;
        t_flags      flg;
    } t_dv;

    typedef struct packed {
        logic [30:0] t;
        logic [35:0] v;
        t_flags      flg;
    } t_tv;

    typedef struct packed {
        logic [30:0] t;
        logic [30:0] ex;
        t_flags      flg;
    } t_te;

endpackage
`default_nettype wire

// ===== sv/ncdf_front.sv =====
// argument magnitude, scaling, clamp, divisor and exponent argument
`default_nettype none
module ncdf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    output logic                        o_rdy,
    input  logic [ncdf_pkg::ARG_W-1:0]  i_arg,
    input  logic                        i_mode,
    output logic                        o_vld,
    input  logic                        i_rdy,
    output ncdf_pkg::t_dv               o_dat
);
    import ncdf_pkg::*;

    localparam int NST = 6;

    logic [NST-1:0] r_vld;
    logic           en;
    t_flags         r_flg [NST];

    logic [45:0] r0_prod;
    logic [15:0] r0_mag;
    logic [30:0] r1_m;
    logic [59:0] r2_pm;
    logic [61:0] r2_mm;
    logic [31:0] r3_d;
    logic [31:0] r3_u;
    logic [62:0] r4_prod;
    logic [31:0] r4_d;
    logic [35:0] r5_v;
    logic [31:0] r5_d;

    logic [15:0] mag;
    logic [31:0] m_raw;

    assign en    = !r_vld[NST-1] || i_rdy;
    assign o_rdy = en;
    assign o_vld = r_vld[NST-1];
    assign o_dat = '{d: r5_d, v: r5_v, flg: r_flg[NST-1]};

    // most negative argument wraps to 32768, which fits unsigned
    assign mag = i_arg[ARG_W-1] ? (~i_arg + 16'd1) : i_arg;

    always_comb begin
        if (r_flg[0].mode) begin
            m_raw = 32'((r0_prod + (46'd1 << (ARG_FRAC + 1))) >> (ARG_FRAC + 2));
        end else begin
            m_raw = 32'(r0_mag) << (28 - ARG_FRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flg[0] <= '{neg: i_arg[ARG_W-1], mode: i_mode};
            for (int i = 1; i < NST; i++) begin
                r_flg[i] <= r_flg[i-1];
            end
            r0_prod <= 46'(mag) * 46'(INV_SQRT2);
            r0_mag  <= mag;
            r1_m    <= (m_raw > 32'(X_LIMIT)) ? X_LIMIT : m_raw[30:0];
            r2_pm   <= 60'(r1_m) * 60'(P_COEF);
            r2_mm   <= 62'(r1_m) * 62'(r1_m);
            r3_d    <= 32'(ONE_Q30) + 32'((r2_pm + (60'd1 << 27)) >> 28);
            r3_u    <= 32'((r2_mm + (62'd1 << 29)) >> 30);
            r4_prod <= 63'(r3_u) * 63'(LOG2E);
            r4_d    <= r3_d;
            r5_v    <= 36'((r4_prod + (63'd1 << 25)) >> 26);
            r5_d    <= r4_d;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ncdf_div.sv =====
// pipelined restoring divider for t = round(2^60 / d), one quotient bit per stage
`default_nettype none
module ncdf_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  ncdf_pkg::t_dv i_dat,
    output logic          o_vld,
    input  logic          i_rdy,
    output ncdf_pkg::t_tv o_dat
);
    import ncdf_pkg::*;

    localparam int NST = 31;

    logic [NST-1:0] r_vld;
    logic           en;

    logic [31:0] r_d   [NST];
    logic [31:0] r_rem [NST];
    logic [30:0] r_q   [NST];
    logic [35:0] r_v   [NST];
    t_flags      r_flg [NST];

    assign en    = !r_vld[NST-1] || i_rdy;
    assign o_rdy = en;
    assign o_vld = r_vld[NST-1];
    assign o_dat = '{t: r_q[NST-1], v: r_v[NST-1], flg: r_flg[NST-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    // numerator 2^60 + d/2: top part leaves 2^29, low 31 bits are d >> 1
    for (genvar j = 0; j < NST; j++) begin : g_stg
        logic [31:0] d_in;
        logic [31:0] rem_in;
        logic [30:0] q_in;
        logic [35:0] v_in;
        t_flags      f_in;
        logic [32:0] tmp;
        logic        ge;

        if (j == 0) begin : g_first
            assign d_in   = i_dat.d;
            assign rem_in = 32'd1 << 29;
            assign q_in   = '0;
            assign v_in   = i_dat.v;
            assign f_in   = i_dat.flg;
        end else begin : g_next
            assign d_in   = r_d[j-1];
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
            assign v_in   = r_v[j-1];
            assign f_in   = r_flg[j-1];
        end

        assign tmp = {rem_in, d_in[31-j]};
        assign ge  = tmp >= {1'b0, d_in};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d[j]   <= d_in;
                r_rem[j] <= ge ? 32'(tmp - {1'b0, d_in}) : tmp[31:0];
                r_q[j]   <= {q_in[29:0], ge};
                r_v[j]   <= v_in;
                r_flg[j] <= f_in;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/ncdf_exp.sv =====
// exp(-m^2) as 2^-f >> n, with a 12-term series for 2^-f
`default_nettype none
module ncdf_exp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  ncdf_pkg::t_tv i_dat,
    output logic          o_vld,
    input  logic          i_rdy,
    output ncdf_pkg::t_te o_dat
);
    import ncdf_pkg::*;

    // 0: f*ln2, 1: round, 2k/2k+1: series term k, 26: last sum, 27: shift
    localparam int NST = 28;

    logic [NST-1:0] r_vld;
    logic           en;

    logic [30:0] r_t   [NST];
    t_flags      r_flg [NST];
    logic [5:0]  r_n   [NST-1];

    logic [59:0] r_wp;
    logic [29:0] r_w    [1:23];
    logic [30:0] r_x    [1:12];
    logic [30:0] r_term [1:12];
    logic [30:0] r_sum  [2:26];
    logic [30:0] r_ex;

    logic [39:0] ex_rnd;
    logic [39:0] ex_sh;

    assign en    = !r_vld[NST-1] || i_rdy;
    assign o_rdy = en;
    assign o_vld = r_vld[NST-1];
    assign o_dat = '{t: r_t[NST-1], ex: r_ex, flg: r_flg[NST-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t[0]   <= i_dat.t;
            r_flg[0] <= i_dat.flg;
            r_n[0]   <= i_dat.v[35:30];
            for (int i = 1; i < NST; i++) begin
                r_t[i]   <= r_t[i-1];
                r_flg[i] <= r_flg[i-1];
            end
            for (int i = 1; i < NST - 1; i++) begin
                r_n[i] <= r_n[i-1];
            end
            r_wp   <= 60'(i_dat.v[29:0]) * 60'(LN2);
            r_w[1] <= 30'((r_wp + (60'd1 << 29)) >> 30);
            for (int i = 2; i <= 23; i++) begin
                r_w[i] <= r_w[i-1];
            end
        end
    end

    for (genvar k = 1; k <= 12; k++) begin : g_term
        localparam int          L   = $clog2(k);
        localparam logic [63:0] RCP = ((64'd1 << (31 + L)) + 64'(k) - 64'd1) / 64'(k);
        localparam logic [60:0] RND = (61'd1 << 29) + (61'(k / 2) << 30);
        logic [30:0] term_in;
        logic [30:0] sum_in;

        if (k == 1) begin : g_first
            assign term_in = ONE_Q30;
            assign sum_in  = ONE_Q30;
        end else if ((k % 2) == 0) begin : g_sub
            assign term_in = r_term[k-1];
            assign sum_in  = r_sum[2*k-1] - r_term[k-1];
        end else begin : g_add
            assign term_in = r_term[k-1];
            assign sum_in  = r_sum[2*k-1] + r_term[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                // rounding and the k/2 bias of the divide folded into one add
                r_x[k]       <= 31'((61'(term_in) * 61'(r_w[2*k-1]) + RND) >> 30);
                r_sum[2*k]   <= sum_in;
                r_term[k]    <= 31'((63'(r_x[k]) * 63'(RCP[31:0])) >> (31 + L));
                r_sum[2*k+1] <= r_sum[2*k];
            end
        end
    end

    always_comb begin
        ex_rnd = (r_n[26] == 6'd0) ? 40'd0 : (40'd1 << (r_n[26] - 6'd1));
        ex_sh  = (40'(r_sum[26]) + ex_rnd) >> r_n[26];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum[26] <= r_sum[25] + r_term[12];
            r_ex      <= (r_n[26] >= 6'd40) ? 31'd0 : ex_sh[30:0];
        end
    end

endmodule
`default_nettype wire

// ===== sv/ncdf_horner.sv =====
// horner polynomial in t, product with exp, and output formatting
`default_nettype none
module ncdf_horner (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    output logic                        o_rdy,
    input  ncdf_pkg::t_te               i_dat,
    output logic                        o_vld,
    input  logic                        i_rdy,
    output logic [ncdf_pkg::VAL_W-1:0]  o_val
);
    import ncdf_pkg::*;

    // step j: multiply at 2j, round and add at 2j+1; 12: clamp, 13: format
    localparam int NST = 14;

    logic [NST-1:0] r_vld;
    logic           en;

    logic [30:0] r_t   [8];
    logic [30:0] r_ex  [10];
    t_flags      r_flg [13];

    logic [62:0]        r_pr [6];
    logic               r_ng [6];
    logic signed [33:0] r_s  [6];
    logic [30:0]        r_y;
    logic [VAL_W-1:0]   r_val;

    logic signed [34:0] yy;
    logic [31:0]        s2;
    logic [31:0]        phi;
    logic [31:0]        e_mag;
    logic [31:0]        e_lim;
    logic [31:0]        lim;

    assign en    = !r_vld[NST-1] || i_rdy;
    assign o_rdy = en;
    assign o_vld = r_vld[NST-1];
    assign o_val = r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t[0]   <= i_dat.t;
            r_ex[0]  <= i_dat.ex;
            r_flg[0] <= i_dat.flg;
            for (int i = 1; i < 8; i++) begin
                r_t[i] <= r_t[i-1];
            end
            for (int i = 1; i < 10; i++) begin
                r_ex[i] <= r_ex[i-1];
            end
            for (int i = 1; i < 13; i++) begin
                r_flg[i] <= r_flg[i-1];
            end
        end
    end

    for (genvar j = 0; j < 6; j++) begin : g_step
        logic signed [33:0] s_in;
        logic [30:0]        b_in;
        logic [31:0]        s_mag;
        logic [33:0]        p;

        if (j == 0) begin : g_first
            assign s_in = COEF_A5;
            assign b_in = i_dat.t;
        end else if (j < 5) begin : g_mid
            assign s_in = r_s[j-1];
            assign b_in = r_t[2*j-1];
        end else begin : g_last
            assign s_in = r_s[j-1];
            assign b_in = r_ex[9];
        end

        // products are rounded on the magnitude
        assign s_mag = s_in[33] ? 32'(-s_in) : 32'(s_in);
        assign p     = 34'((r_pr[j] + (63'd1 << 29)) >> 30);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pr[j] <= 63'(s_mag) * 63'(b_in);
                r_ng[j] <= s_in[33];
                r_s[j]  <= (r_ng[j] ? -p : p) + COEF_ADD[j];
            end
        end
    end

    always_comb begin
        yy    = $signed(35'(ONE_Q30)) - $signed({r_s[5][33], r_s[5]});
        lim   = 32'd1 << RES_FRAC;
        s2    = r_flg[12].neg ? (32'(ONE_Q30) - 32'(r_y)) : (32'(ONE_Q30) + 32'(r_y));
        phi   = (s2 + (32'd1 << (30 - RES_FRAC))) >> (31 - RES_FRAC);
        e_mag = (32'(r_y) + (32'd1 << (29 - RES_FRAC))) >> (30 - RES_FRAC);
        e_lim = (e_mag > lim) ? lim : e_mag;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (yy[34]) begin
                r_y <= '0;
            end else if (yy > $signed(35'(ONE_Q30))) begin
                r_y <= ONE_Q30;
            end else begin
                r_y <= yy[30:0];
            end
            if (r_flg[12].mode) begin
                r_val <= VAL_W'((phi > lim) ? lim : phi);
            end else begin
                r_val <= r_flg[12].neg ? VAL_W'(-e_lim) : VAL_W'(e_lim);
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/normal_cdf_erf_approx.sv =====
// top level: erf / standard normal cdf evaluator
`default_nettype none
// Evaluates erf(x) or the standard normal CDF Phi(x) for a signed Q12 argument,
// selected by the cdf_mode register (1 after reset: Phi). The result is signed
// Q16, clamped to [-1,1] for erf and [0,1] for Phi. The datapath is fully
// pipelined: one argument is taken every cycle while the front is not stalled,
// and each result passes through 6 front stages, 31 divider stages producing one
// quotient bit of t = 1/(1+p|x|) each, 28 stages for exp(-x^2) with two per
// series term, and 14 for the Horner polynomial and output rounding. Back
// pressure stalls each section only while its last register is full, so
// empty slots are filled while a result waits. cdf_mode is sampled with each
// argument and must only be written while the block is idle.
module normal_cdf_erf_approx (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_arg_valid,
    output logic                        o_arg_ready,
    input  logic [ncdf_pkg::ARG_W-1:0]  i_arg,
    output logic                        o_value_valid,
    input  logic                        i_value_ready,
    output logic [ncdf_pkg::VAL_W-1:0]  o_value,
    input  logic                        i_cdf_mode_we,
    input  logic                        i_cdf_mode_wdata
);
    import ncdf_pkg::*;

    logic r_cdf_mode;

    logic fr_vld, fr_rdy;
    logic dv_vld, dv_rdy;
    logic ex_vld, ex_rdy;
    t_dv  fr_dat;
    t_tv  dv_dat;
    t_te  ex_dat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cdf_mode <= 1'b1;
        end else if (i_cdf_mode_we) begin
            r_cdf_mode <= i_cdf_mode_wdata;
        end
    end

    ncdf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_arg_valid),
        .o_rdy   (o_arg_ready),
        .i_arg   (i_arg),
        .i_mode  (r_cdf_mode),
        .o_vld   (fr_vld),
        .i_rdy   (fr_rdy),
        .o_dat   (fr_dat)
    );

    ncdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (fr_vld),
        .o_rdy   (fr_rdy),
        .i_dat   (fr_dat),
        .o_vld   (dv_vld),
        .i_rdy   (dv_rdy),
        .o_dat   (dv_dat)
    );

    ncdf_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (dv_vld),
        .o_rdy   (dv_rdy),
        .i_dat   (dv_dat),
        .o_vld   (ex_vld),
        .i_rdy   (ex_rdy),
        .o_dat   (ex_dat)
    );

    ncdf_horner u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (ex_vld),
        .o_rdy   (ex_rdy),
        .i_dat   (ex_dat),
        .o_vld   (o_value_valid),
        .i_rdy   (i_value_ready),
        .o_val   (o_value)
    );

endmodule
`default_nettype wire

// ===== sv/ncdf_chk.sv =====
// port-level checker for the erf / normal cdf block, bound to the top level
`default_nettype none
`include "normal_cdf_erf_approx_macros.svh"
module ncdf_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_arg_ready,
    input  logic                        i_value_valid,
    input  logic                        i_value_ready,
    input  logic [ncdf_pkg::VAL_W-1:0]  i_value
);
    import ncdf_pkg::*;

    // nothing comes out right after reset
    `NCDF_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_value_valid, "valid after reset")

    // with the output register empty the whole pipeline can move
    `NCDF_ASSERT(a_ready_free, i_clk, i_rst_n, !i_value_valid |-> i_arg_ready, "stall with empty output")

    // results never leave the clamp range
    `NCDF_ASSERT(a_range, i_clk, i_rst_n, i_value_valid |-> (($signed(i_value) <= 18'sd65536) && ($signed(i_value) >= -18'sd65536)), "result out of range")

    // a stalled transaction holds its value
    `NCDF_ASSERT(a_hold, i_clk, i_rst_n, (i_value_valid && !i_value_ready) |=> (i_value_valid && $stable(i_value)), "stalled result changed")

endmodule

bind normal_cdf_erf_approx ncdf_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_arg_ready   (o_arg_ready),
    .i_value_valid (o_value_valid),
    .i_value_ready (i_value_ready),
    .i_value       (o_value)
);
`default_nettype wire
